// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLFE_AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plfe check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLFE_AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plfe check failed");

`endif

// ===== rtl/core/plfe_pkg.sv =====
package plfe_pkg;

  localparam int PAYLOAD_BITS_DEF = 14;
  localparam int TICK_W           = 10;
  localparam int POS_OUT_W        = 5;
  localparam int CFG_IDX_W        = 3;

  localparam logic [TICK_W-1:0] END_TICKS_RST  = 10'd150;
  localparam logic [TICK_W-1:0] ONE_TICKS_RST  = 10'd75;
  localparam logic [TICK_W-1:0] ZERO_TICKS_RST = 10'd50;
  localparam logic [TICK_W-1:0] GAP_TICKS_RST  = 10'd25;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = 3'd4;

  typedef struct packed {
    logic [TICK_W-1:0] end_ticks;
    logic [TICK_W-1:0] one_ticks;
    logic [TICK_W-1:0] zero_ticks;
    logic [TICK_W-1:0] gap_ticks;
  } sym_len_t;

  typedef struct packed {
    logic              carrier_on;
    logic              frame_done;
    logic [TICK_W-1:0] ticks_left;
  } tick_res_t;

  // Frame position runs from payload_bits+2 down to 0
  function automatic int pos_width(input int payload_bits);
    return $clog2(payload_bits + 3);
  endfunction

  function automatic int idx_width(input int payload_bits);
    return (payload_bits > 1) ? $clog2(payload_bits) : 1;
  endfunction

endpackage

// ===== rtl/core/plfe_tick.sv =====
module plfe_tick #(
  parameter int PAYLOAD_BITS = plfe_pkg::PAYLOAD_BITS_DEF,
  localparam int PosW = plfe_pkg::pos_width(PAYLOAD_BITS)
) (
  input  logic                                restart,
  input  logic [plfe_pkg::TICK_W-1:0]         ticks_left,
  input  logic [PosW-1:0]                     frame_pos,
  input  logic [PAYLOAD_BITS-1:0]             payload,
  input  plfe_pkg::sym_len_t                  lens,
  output plfe_pkg::tick_res_t                 res,
  output logic [PosW-1:0]                     frame_pos_nxt
);

  localparam int IdxW = plfe_pkg::idx_width(PAYLOAD_BITS);
  localparam logic [PosW-1:0] FirstPos = PosW'(PAYLOAD_BITS + 2);
  localparam logic [PosW-1:0] LastBit  = PosW'(PAYLOAD_BITS);

  logic [plfe_pkg::TICK_W-1:0] tl0;
  logic [plfe_pkg::TICK_W-1:0] tl1;
  logic [plfe_pkg::TICK_W-1:0] len;
  logic [PosW-1:0]             pos0;
  logic [PosW-1:0]             pos1;
  logic [IdxW-1:0]             bit_idx;
  logic                        wrap;
  logic                        in_payload;

  always_comb begin
    tl0  = restart ? lens.end_ticks : ticks_left;
    pos0 = restart ? FirstPos : frame_pos;
    // counter wraps: a zero-length symbol lasts a full 1024 ticks
    tl1  = tl0 - plfe_pkg::TICK_W'(1);
    wrap = (tl1 == '0);
    pos1 = (wrap && (pos0 != '0)) ? pos0 - PosW'(1) : pos0;

    in_payload = (pos1 != '0) && (pos1 <= LastBit);
    bit_idx    = IdxW'(pos1 - PosW'(1));
    if (in_payload) begin
      len = payload[bit_idx] ? lens.one_ticks : lens.zero_ticks;
    end else begin
      len = lens.end_ticks;
    end

    res.carrier_on = (tl1 > lens.gap_ticks);
    res.frame_done = (pos1 == '0);
    res.ticks_left = wrap ? len : tl1;
    frame_pos_nxt  = pos1;
  end

endmodule

// ===== rtl/core/pulse_length_frame_encoder_unit.sv =====
// Channel  Direction  Handshake             Beat contents
// in_      input      in_valid / in_stall   in_restart
// out_     output     out_valid / out_stall out_carrier_on, out_symbol_pos, out_frame_done
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// One tick per clock when out_stall stays low; an input beat becomes a result beat through
// the input register, then the decrement/compare into the output register.
// Symbol counter and frame position advance only when a tick moves into the output register.
// rst_n is synchronous, active low; lengths return to their defaults, payload to zero.
// cfg_ready is always high; writes to unknown indexes are dropped.
// A stalled output holds its beat; in_stall rises only while both stages are full.
module pulse_length_frame_encoder_unit #(
  parameter int PAYLOAD_BITS = plfe_pkg::PAYLOAD_BITS_DEF,
  localparam int CfgW = (PAYLOAD_BITS > plfe_pkg::TICK_W) ? PAYLOAD_BITS : plfe_pkg::TICK_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_carrier_on,
  output logic [plfe_pkg::POS_OUT_W-1:0]    out_symbol_pos,
  output logic                              out_frame_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [plfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CfgW-1:0]                   cfg_wdata
);

  localparam int PosW = plfe_pkg::pos_width(PAYLOAD_BITS);

  logic [PAYLOAD_BITS-1:0]      payload_r;
  plfe_pkg::sym_len_t           lens_r;
  logic [plfe_pkg::TICK_W-1:0]  ticks_left_r;
  logic [PosW-1:0]              frame_pos_r;
  logic                         s1_valid_r;
  logic                         s1_restart_r;
  logic                         out_valid_r;
  logic                         out_carrier_on_r;
  logic [plfe_pkg::POS_OUT_W-1:0] out_symbol_pos_r;
  logic                         out_frame_done_r;

  plfe_pkg::tick_res_t          tick_res;
  logic [PosW-1:0]              frame_pos_nxt;
  logic                         out_adv;
  logic                         fire;
  logic                         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_r         <= '0;
      lens_r.end_ticks  <= plfe_pkg::END_TICKS_RST;
      lens_r.one_ticks  <= plfe_pkg::ONE_TICKS_RST;
      lens_r.zero_ticks <= plfe_pkg::ZERO_TICKS_RST;
      lens_r.gap_ticks  <= plfe_pkg::GAP_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        plfe_pkg::REG_PAYLOAD:    payload_r         <= cfg_wdata[PAYLOAD_BITS-1:0];
        plfe_pkg::REG_END_TICKS:  lens_r.end_ticks  <= cfg_wdata[plfe_pkg::TICK_W-1:0];
        plfe_pkg::REG_ONE_TICKS:  lens_r.one_ticks  <= cfg_wdata[plfe_pkg::TICK_W-1:0];
        plfe_pkg::REG_ZERO_TICKS: lens_r.zero_ticks <= cfg_wdata[plfe_pkg::TICK_W-1:0];
        plfe_pkg::REG_GAP_TICKS:  lens_r.gap_ticks  <= cfg_wdata[plfe_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // output register frees up when empty or when its beat is taken
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign fire     = s1_valid_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_restart_r <= in_restart;
    end
  end

  plfe_tick #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_tick (
    .restart       (s1_restart_r),
    .ticks_left    (ticks_left_r),
    .frame_pos     (frame_pos_r),
    .payload       (payload_r),
    .lens          (lens_r),
    .res           (tick_res),
    .frame_pos_nxt (frame_pos_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_left_r <= plfe_pkg::END_TICKS_RST;
      frame_pos_r  <= PosW'(PAYLOAD_BITS + 2);
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        ticks_left_r <= tick_res.ticks_left;
        frame_pos_r  <= frame_pos_nxt;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_carrier_on_r <= tick_res.carrier_on;
      out_symbol_pos_r <= plfe_pkg::POS_OUT_W'(frame_pos_nxt);
      out_frame_done_r <= tick_res.frame_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_carrier_on = out_carrier_on_r;
  assign out_symbol_pos = out_symbol_pos_r;
  assign out_frame_done = out_frame_done_r;

endmodule

// ===== rtl/core/plfe_chk.sv =====
`include "assert_macros.svh"

module plfe_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_carrier_on,
  input logic [plfe_pkg::POS_OUT_W-1:0] out_symbol_pos,
  input logic                           out_frame_done
);

  // hold a stalled result beat
  `PLFE_AST_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_carrier_on, out_symbol_pos, out_frame_done}))

  // frame done only on the final marker position
  `PLFE_AST_IMP(a_done_pos, clk, rst_n, out_valid && out_frame_done, out_symbol_pos == '0)

  // empty output register never back-pressures the input
  `PLFE_AST_IMP(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

  // nothing to deliver straight after reset
  `PLFE_AST_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid && !in_stall)

endmodule

bind pulse_length_frame_encoder_unit plfe_chk u_plfe_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_carrier_on (out_carrier_on),
  .out_symbol_pos (out_symbol_pos),
  .out_frame_done (out_frame_done)
);
